// ----- rtl/drct_pkg.sv -----
// ----------------------------------------------------------------------------
// Dirty row clock table package
// Shared constants, operation codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package drct_pkg;

   localparam int TABLE_ROWS_DEF = 1024;

   localparam int FUNC_W  = 3;
   localparam int ROW_W   = 10;
   localparam int CLOCK_W = 31;
   localparam int COUNT_W = 11;
   localparam int ENTRY_W = 32;

   localparam logic [ENTRY_W-1:0] CLOCK_INVALID = '1;
   localparam logic [COUNT_W-1:0] FRESH_MAX     = '1;

   localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd0;
   localparam logic [FUNC_W-1:0] FN_TAKE       = 3'd1;
   localparam logic [FUNC_W-1:0] FN_NEXT_ORDER = 3'd2;
   localparam logic [FUNC_W-1:0] FN_START_UPTO = 3'd3;
   localparam logic [FUNC_W-1:0] FN_NEXT_UPTO  = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_CHK,
      ST_SCAN,
      ST_POST
   } state_type;

   typedef struct packed {
      logic               found;
      logic [ROW_W-1:0]   row;
      logic [COUNT_W-1:0] dirty;
      logic [COUNT_W-1:0] fresh;
   } res_type;

endpackage

`default_nettype wire

// ----- rtl/drct_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module drct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire                     rd_en,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/drct_ctrl.sv -----
// ----------------------------------------------------------------------------
// Dirty row clock table sequencer
// Clears the table after reset, runs each operation and scans the table one
// entry per cycle through a shared entry test.
// ----------------------------------------------------------------------------
`default_nettype none

module drct_ctrl import drct_pkg::*; #(
   parameter int TABLE_ROWS = TABLE_ROWS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire [FUNC_W-1:0]               req_func,
   input  wire [ROW_W-1:0]                req_row_index_in,
   input  wire [CLOCK_W-1:0]              req_clock_value,
   output logic                           ram_wr_en,
   output logic [$clog2(TABLE_ROWS)-1:0]  ram_wr_addr,
   output logic [ENTRY_W-1:0]             ram_wr_data,
   output logic                           ram_rd_en,
   output logic [$clog2(TABLE_ROWS)-1:0]  ram_rd_addr,
   input  wire [ENTRY_W-1:0]              ram_rd_data,
   output logic                           res_valid,
   output res_type                        res,
   input  wire                            out_free
);

   localparam int IW = $clog2(TABLE_ROWS);
   localparam int CW = $clog2(TABLE_ROWS + 1);
   localparam logic [IW-1:0] LAST_ROW = IW'(TABLE_ROWS - 1);
   localparam logic [CW-1:0] AT_END   = CW'(TABLE_ROWS);

   state_type state_ff, state_in;
   logic [IW-1:0]      clr_idx_ff, clr_idx_in;
   logic [CW-1:0]      dirty_ff, dirty_in;
   logic [COUNT_W-1:0] fresh_ff, fresh_in;
   logic [CW-1:0]      cursor_ff, cursor_in;
   logic [CLOCK_W-1:0] limit_ff, limit_in;
   logic               iss_on_ff, iss_on_in;
   logic [IW-1:0]      iss_idx_ff, iss_idx_in;
   logic               chk_v_ff, chk_v_in;
   logic               chk_last_ff, chk_last_in;
   logic [IW-1:0]      chk_idx_ff, chk_idx_in;
   logic               wrap_ff, wrap_in;
   logic [FUNC_W-1:0]  op_ff, op_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [CLOCK_W-1:0] clk_ff, clk_in;
   logic               found_ff, found_in;
   logic [IW-1:0]      res_row_ff, res_row_in;

   logic          hit;
   logic          row_ok;
   logic [IW-1:0] iss_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
         dirty_ff   <= '0;
         fresh_ff   <= '0;
         cursor_ff  <= '0;
         limit_ff   <= '0;
         iss_on_ff  <= 1'b0;
         chk_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
         dirty_ff   <= dirty_in;
         fresh_ff   <= fresh_in;
         cursor_ff  <= cursor_in;
         limit_ff   <= limit_in;
         iss_on_ff  <= iss_on_in;
         chk_v_ff   <= chk_v_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_idx_ff  <= iss_idx_in;
      chk_last_ff <= chk_last_in;
      chk_idx_ff  <= chk_idx_in;
      wrap_ff     <= wrap_in;
      op_ff       <= op_in;
      row_ff      <= row_in;
      clk_ff      <= clk_in;
      found_ff    <= found_in;
      res_row_ff  <= res_row_in;
   end

   // A row matches when it is dirty and, for the limited scan, its clock is
   // at or below the clear limit.
   assign hit = chk_v_ff && !ram_rd_data[ENTRY_W-1] &&
                (wrap_ff || (ram_rd_data[CLOCK_W-1:0] <= limit_ff));
   assign row_ok   = 32'(row_ff) < 32'(TABLE_ROWS);
   assign iss_next = (iss_idx_ff == LAST_ROW) ? '0 : iss_idx_ff + 1'b1;

   always_comb begin
      state_in    = state_ff;
      clr_idx_in  = clr_idx_ff;
      dirty_in    = dirty_ff;
      fresh_in    = fresh_ff;
      cursor_in   = cursor_ff;
      limit_in    = limit_ff;
      iss_on_in   = iss_on_ff;
      iss_idx_in  = iss_idx_ff;
      chk_v_in    = 1'b0;
      chk_last_in = chk_last_ff;
      chk_idx_in  = chk_idx_ff;
      wrap_in     = wrap_ff;
      op_in       = op_ff;
      row_in      = row_ff;
      clk_in      = clk_ff;
      found_in    = found_ff;
      res_row_in  = res_row_ff;
      req_stall   = 1'b1;
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_idx_ff;
      ram_wr_data = CLOCK_INVALID;
      ram_rd_en   = 1'b0;
      ram_rd_addr = iss_idx_ff;
      res_valid   = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en  = 1'b1;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in    = req_func;
               row_in   = req_row_index_in;
               clk_in   = req_clock_value;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            found_in   = 1'b0;
            res_row_in = '0;
            iss_on_in  = 1'b0;
            state_in   = ST_POST;
            unique case (op_ff)
               FN_INSERT: begin
                  if (row_ok) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = IW'(row_ff);
                     state_in    = ST_INS_CHK;
                  end
               end
               FN_NEXT_ORDER: begin
                  if (dirty_ff != '0 && cursor_ff != AT_END) begin
                     wrap_in    = 1'b1;
                     iss_on_in  = 1'b1;
                     iss_idx_in = IW'(cursor_ff);
                     state_in   = ST_SCAN;
                  end
               end
               FN_START_UPTO: begin
                  cursor_in = '0;
                  limit_in  = clk_ff;
                  if (dirty_ff != '0) begin
                     wrap_in    = 1'b0;
                     iss_on_in  = 1'b1;
                     iss_idx_in = '0;
                     state_in   = ST_SCAN;
                  end
               end
               FN_NEXT_UPTO: begin
                  if (dirty_ff != '0) begin
                     if (cursor_ff == AT_END) begin
                        cursor_in = AT_END;
                     end else begin
                        wrap_in    = 1'b0;
                        iss_on_in  = 1'b1;
                        iss_idx_in = IW'(cursor_ff);
                        state_in   = ST_SCAN;
                     end
                  end
               end
               default: begin
                  state_in = ST_POST;
               end
            endcase
         end
         ST_INS_CHK: begin
            if (ram_rd_data[ENTRY_W-1]) begin
               dirty_in = dirty_ff + 1'b1;
               if (fresh_ff != FRESH_MAX) begin
                  fresh_in = fresh_ff + 1'b1;
               end
            end
            ram_wr_en   = 1'b1;
            ram_wr_addr = IW'(row_ff);
            ram_wr_data = {1'b0, clk_ff};
            state_in    = ST_POST;
         end
         ST_SCAN: begin
            if (hit) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = chk_idx_ff;
               ram_wr_data = CLOCK_INVALID;
               if (dirty_ff != '0) begin
                  dirty_in = dirty_ff - 1'b1;
               end
               cursor_in  = CW'(chk_idx_ff);
               found_in   = 1'b1;
               res_row_in = chk_idx_ff;
               iss_on_in  = 1'b0;
               state_in   = ST_POST;
            end else if (chk_v_ff && chk_last_ff) begin
               cursor_in = AT_END;
               iss_on_in = 1'b0;
               state_in  = ST_POST;
            end else if (iss_on_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = iss_idx_ff;
               chk_v_in    = 1'b1;
               chk_idx_in  = iss_idx_ff;
               chk_last_in = !wrap_ff && (iss_idx_ff == LAST_ROW);
               iss_on_in   = wrap_ff || (iss_idx_ff != LAST_ROW);
               iss_idx_in  = iss_next;
            end
         end
         ST_POST: begin
            res_valid = 1'b1;
            if (out_free) begin
               if (op_ff == FN_TAKE) begin
                  fresh_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res.found = found_ff;
   assign res.row   = ROW_W'(res_row_ff);
   assign res.dirty = COUNT_W'(dirty_ff);
   assign res.fresh = fresh_ff;

endmodule

`default_nettype wire

// ----- rtl/dirty_row_clock_table.sv -----
// An insert to a row in the table runs through dispatch, a row check and the result
// state; take, undefined codes and operations with no row to scan go from dispatch
// to the result state; a scan visits one table row per cycle, up to TABLE_ROWS rows.
// One item at a time; the request channel opens again in the cycle after the
// result enters the output register, and a stalled output holds the sequencer.
// After reset a clearing pass over all TABLE_ROWS rows marks every row clean with
// req_stall high; the result register comes up empty.
// ----------------------------------------------------------------------------
// Dirty row clock table
// Per-row clock table with dirty and new counts, ordered and limited scans,
// and a registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dirty_row_clock_table import drct_pkg::*; #(
   parameter int TABLE_ROWS = TABLE_ROWS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire [FUNC_W-1:0]   req_func,
   input  wire [ROW_W-1:0]    req_row_index_in,
   input  wire [CLOCK_W-1:0]  req_clock_value,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic               rsp_found,
   output logic [ROW_W-1:0]   rsp_row_index_out,
   output logic [COUNT_W-1:0] rsp_dirty_count,
   output logic [COUNT_W-1:0] rsp_new_count
);

   localparam int IW = $clog2(TABLE_ROWS);

   logic               ram_wr_en;
   logic [IW-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [IW-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic               res_valid;
   res_type            res;
   logic               out_free;
   logic               rsp_valid_ff, rsp_valid_in;
   res_type            rsp_ff, rsp_in;

   drct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   drct_ctrl #(
      .TABLE_ROWS (TABLE_ROWS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_row_index_in (req_row_index_in),
      .req_clock_value  (req_clock_value),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .res_valid        (res_valid),
      .res              (res),
      .out_free         (out_free)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_ff.found;
   assign rsp_row_index_out = rsp_ff.row;
   assign rsp_dirty_count   = rsp_ff.dirty;
   assign rsp_new_count     = rsp_ff.fresh;

endmodule

`default_nettype wire

// ----- rtl/drct_check.sv -----
// ----------------------------------------------------------------------------
// Dirty row clock table checker
// Port-level assertions on the request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module drct_check import drct_pkg::*; (
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_stall,
   input wire                rsp_valid,
   input wire                rsp_stall,
   input wire                rsp_found,
   input wire [ROW_W-1:0]    rsp_row_index_out,
   input wire [COUNT_W-1:0]  rsp_dirty_count,
   input wire [COUNT_W-1:0]  rsp_new_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_row_index_out) && $stable(rsp_dirty_count) && $stable(rsp_new_count))
      else $error("Stalled result item changed.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Request channel open right after an item was accepted.");

   a_row_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_row_index_out == '0)
      else $error("Row index is nonzero on an item with no row found.");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("Block not held in its clearing pass after reset.");

endmodule

bind dirty_row_clock_table drct_check u_drct_check (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_found         (rsp_found),
   .rsp_row_index_out (rsp_row_index_out),
   .rsp_dirty_count   (rsp_dirty_count),
   .rsp_new_count     (rsp_new_count)
);

`default_nettype wire
